// ===== design/upa_pkg.sv =====
package upa_pkg;

  localparam int PIX_W     = 8;
  localparam int DEPTH_W   = 16;
  localparam int FACTOR_W  = 16;
  localparam int RANGE_W   = 32;
  localparam int ATTEN_W   = 16;
  localparam int ARG_W     = 48;
  localparam int ARG_FRAC  = 38;
  localparam int ARG_INT_W = 4;
  localparam int ACC_W     = 25;
  localparam int TAB_W     = 24;
  localparam int TAB_N     = 16;
  localparam int TAB_OFS   = 12;
  localparam int E_W       = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [RANGE_W-1:0] RANGE_MIN = 32'd4195;
  localparam logic [ACC_W-1:0]   ONE_Q24   = 25'd16777216;
  localparam logic [E_W-1:0]     E_ONE     = 17'd65536;

  typedef logic [2:0][PIX_W-1:0]   pix3_t;
  typedef logic [2:0][ATTEN_W-1:0] atten3_t;
  typedef logic [2:0][ACC_W-1:0]   acc3_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTEN_RED   = 3'd0,
    CFG_ATTEN_GREEN = 3'd1,
    CFG_ATTEN_BLUE  = 3'd2,
    CFG_BACK_RED    = 3'd3,
    CFG_BACK_GREEN  = 3'd4,
    CFG_BACK_BLUE   = 3'd5
  } cfg_idx_t;

  // exp(-2^k), Q0.24, k = -12 .. 3
  localparam logic [TAB_N-1:0][TAB_W-1:0] EXP_TAB = {
    24'd5628,     24'd307285,   24'd2270549,  24'd6171993,
    24'd10175896, 24'd13066109, 24'd14805841, 24'd15760736,
    24'd16261035, 24'd16517109, 24'd16646655, 24'd16711808,
    24'd16744480, 24'd16760840, 24'd16769026, 24'd16773120
  };

endpackage

// ===== design/upa_range.sv =====
module upa_range (
  input  logic                          clk,
  input  logic                          en,
  input  logic [upa_pkg::DEPTH_W-1:0]   depth,
  input  logic [upa_pkg::FACTOR_W-1:0]  factor,
  input  upa_pkg::pix3_t                pix,
  output logic [upa_pkg::RANGE_W-1:0]   range_r,
  output upa_pkg::pix3_t                pix_r,
  output logic                          short_r
);
  import upa_pkg::*;

  logic [RANGE_W-1:0] range_nxt;

  assign range_nxt = RANGE_W'(depth) * RANGE_W'(factor);

  always_ff @(posedge clk) begin
    if (en) begin
      range_r <= range_nxt;
      pix_r   <= pix;
      short_r <= (range_nxt < RANGE_MIN);
    end
  end

endmodule

// ===== design/upa_arg.sv =====
module upa_arg #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [upa_pkg::RANGE_W-1:0]         range_in,
  input  upa_pkg::pix3_t                      pix,
  input  logic                                short_in,
  input  upa_pkg::atten3_t                    atten,
  output upa_pkg::acc3_t                      acc_r,
  output logic [2:0][EXP_TABLE_BITS+3:0]      xq_r,
  output upa_pkg::pix3_t                      pix_r
);
  import upa_pkg::*;

  localparam int XQ_W = EXP_TABLE_BITS + ARG_INT_W;

  logic [2:0][ARG_W-1:0] arg;
  acc3_t                 acc_nxt;
  logic [2:0][XQ_W-1:0]  xq_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      arg[c]     = ARG_W'(range_in) * ARG_W'(atten[c]);
      xq_nxt[c]  = arg[c][ARG_FRAC+ARG_INT_W-1 -: XQ_W];
      // short range or argument >= 16: transmittance is zero
      acc_nxt[c] = (short_in || (arg[c][ARG_W-1:ARG_FRAC+ARG_INT_W] != '0)) ? '0 : ONE_Q24;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      xq_r  <= xq_nxt;
      pix_r <= pix;
    end
  end

endmodule

// ===== design/upa_exp_step.sv =====
module upa_exp_step #(
  parameter int EXP_TABLE_BITS = 8,
  parameter int BIT_POS        = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  upa_pkg::acc3_t                  acc,
  input  logic [2:0][EXP_TABLE_BITS+3:0]  xq,
  input  upa_pkg::pix3_t                  pix,
  output upa_pkg::acc3_t                  acc_r,
  output logic [2:0][EXP_TABLE_BITS+3:0]  xq_r,
  output upa_pkg::pix3_t                  pix_r
);
  import upa_pkg::*;

  localparam int TAB_IDX = BIT_POS + TAB_OFS - EXP_TABLE_BITS;
  localparam logic [TAB_W-1:0] FACTOR = EXP_TAB[TAB_IDX];
  localparam int PROD_W = ACC_W + TAB_W;

  logic [2:0][PROD_W-1:0] prod;
  acc3_t                  acc_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]    = PROD_W'(acc[c]) * PROD_W'(FACTOR);
      acc_nxt[c] = xq[c][BIT_POS] ? prod[c][TAB_W +: ACC_W] : acc[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      xq_r  <= xq;
      pix_r <= pix;
    end
  end

endmodule

// ===== design/upa_blend.sv =====
module upa_blend (
  input  logic            clk,
  input  logic            en,
  input  upa_pkg::acc3_t  acc,
  input  upa_pkg::pix3_t  pix,
  input  upa_pkg::pix3_t  back,
  output upa_pkg::pix3_t  res_r
);
  import upa_pkg::*;

  localparam int SUM_W = E_W + PIX_W + 1;

  logic [2:0][E_W-1:0]   e;
  logic [2:0][E_W-1:0]   e_inv;
  logic [2:0][SUM_W-1:0] sum;
  pix3_t                 res_nxt;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e[c]       = acc[c][ACC_W-1 -: E_W];
      e_inv[c]   = E_ONE - e[c];
      sum[c]     = SUM_W'(e[c]) * SUM_W'(pix[c]) + SUM_W'(e_inv[c]) * SUM_W'(back[c]);
      res_nxt[c] = sum[c][16 +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== design/underwater_pixel_attenuation_top.sv =====
// Underwater attenuation of an RGB pixel stream: range = depth * factor, per-channel
// transmittance e = exp(-range * atten) built from a product of exp(-2^k) constants, and
// result = (e * pixel + (1 - e) * background) >> 16. Ranges under 1 mm return the
// background. One pixel per clock while out_stall is low. Stages: range, argument, one
// registered multiply per bit of the Q4.EXP_TABLE_BITS argument, blend. Bubbles in the
// pipeline are squeezed out under out_stall. Write attenuation and background registers
// only while no pixels are in flight; cfg_ready is always high.
module underwater_pixel_attenuation_top #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [upa_pkg::PIX_W-1:0]       in_pix_red,
  input  logic [upa_pkg::PIX_W-1:0]       in_pix_green,
  input  logic [upa_pkg::PIX_W-1:0]       in_pix_blue,
  input  logic [upa_pkg::DEPTH_W-1:0]     in_pix_depth,
  input  logic [upa_pkg::FACTOR_W-1:0]    in_range_factor,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [upa_pkg::PIX_W-1:0]       out_res_red,
  output logic [upa_pkg::PIX_W-1:0]       out_res_green,
  output logic [upa_pkg::PIX_W-1:0]       out_res_blue,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [upa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [upa_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import upa_pkg::*;

  localparam int XQ_W  = EXP_TABLE_BITS + ARG_INT_W;
  localparam int N_EXP = XQ_W;
  localparam int NS    = N_EXP + 3;

  atten3_t atten_r;
  pix3_t   back_r;

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS-1:0] en;

  pix3_t              pix_in;
  logic [RANGE_W-1:0] range_s;
  pix3_t              pix_s1;
  logic               short_s;

  acc3_t                acc_s [N_EXP+1];
  logic [2:0][XQ_W-1:0] xq_s  [N_EXP+1];
  pix3_t                pix_s [N_EXP+1];
  pix3_t                res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atten_r <= {3{16'd2185}};
      back_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATTEN_RED:   atten_r[0] <= cfg_data;
        CFG_ATTEN_GREEN: atten_r[1] <= cfg_data;
        CFG_ATTEN_BLUE:  atten_r[2] <= cfg_data;
        CFG_BACK_RED:    back_r[0]  <= cfg_data[PIX_W-1:0];
        CFG_BACK_GREEN:  back_r[1]  <= cfg_data[PIX_W-1:0];
        CFG_BACK_BLUE:   back_r[2]  <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // stage loads when empty or when the stage ahead moves
  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int k = NS-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NS; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !en[0];
  assign pix_in   = {in_pix_blue, in_pix_green, in_pix_red};

  upa_range u_range (
    .clk     (clk),
    .en      (en[0]),
    .depth   (in_pix_depth),
    .factor  (in_range_factor),
    .pix     (pix_in),
    .range_r (range_s),
    .pix_r   (pix_s1),
    .short_r (short_s)
  );

  upa_arg #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_arg (
    .clk      (clk),
    .en       (en[1]),
    .range_in (range_s),
    .pix      (pix_s1),
    .short_in (short_s),
    .atten    (atten_r),
    .acc_r    (acc_s[0]),
    .xq_r     (xq_s[0]),
    .pix_r    (pix_s[0])
  );

  for (genvar k = 0; k < N_EXP; k++) begin : g_exp
    upa_exp_step #(.EXP_TABLE_BITS(EXP_TABLE_BITS), .BIT_POS(k)) u_step (
      .clk   (clk),
      .en    (en[k+2]),
      .acc   (acc_s[k]),
      .xq    (xq_s[k]),
      .pix   (pix_s[k]),
      .acc_r (acc_s[k+1]),
      .xq_r  (xq_s[k+1]),
      .pix_r (pix_s[k+1])
    );
  end

  upa_blend u_blend (
    .clk   (clk),
    .en    (en[NS-1]),
    .acc   (acc_s[N_EXP]),
    .pix   (pix_s[N_EXP]),
    .back  (back_r),
    .res_r (res)
  );

  assign out_valid     = v_r[NS-1];
  assign out_res_red   = res[0];
  assign out_res_green = res[1];
  assign out_res_blue  = res[2];

endmodule
